// ===== sv/srrw_pkg.sv =====
// ----------------------------------------------------------------------------
// srrw_pkg: shared types and constants of the selective-repeat receive window
// Holds the packet and result codes, the sequence unit opcodes and the layout
// of one buffered slot entry.
// ----------------------------------------------------------------------------
package srrw_pkg;

    // Packet kinds on the input channel.
    localparam logic PK_DATA = 1'b0;
    localparam logic PK_EOT  = 1'b1;

    // Result kinds on the output channel.
    localparam logic [1:0] RK_DELIVER = 2'd0;
    localparam logic [1:0] RK_ACK     = 2'd1;
    localparam logic [1:0] RK_EOT     = 2'd2;

    // Window register reset value and upper bound.
    localparam logic [4:0] WIN_RESET = 5'd10;
    localparam int         WIN_CAP   = 16;

    // Operations of the shared sequence-number unit.
    typedef enum logic {
        OP_DIFF,
        OP_INC
    } alu_op_t;

    // One buffered entry: payload descriptor and byte count.
    typedef struct packed {
        logic [31:0] handle;
        logic [9:0]  length;
    } slot_entry_t;

endpackage

// ===== sv/srrw_in_if.sv =====
// ----------------------------------------------------------------------------
// srrw_in_if: packet channel
// Valid/ready channel that carries one received packet per transfer.
// ----------------------------------------------------------------------------
interface srrw_in_if;
    logic        valid;
    logic        ready;
    logic        packet_kind;
    logic [4:0]  seq_num;
    logic [31:0] payload_handle;
    logic [9:0]  payload_length;

    modport source (
        output valid, packet_kind, seq_num, payload_handle, payload_length,
        input  ready
    );

    modport sink (
        input  valid, packet_kind, seq_num, payload_handle, payload_length,
        output ready
    );
endinterface

// ===== sv/srrw_out_if.sv =====
// ----------------------------------------------------------------------------
// srrw_out_if: result channel
// Valid/ready channel that carries one delivery, ack or EOT reply per transfer.
// ----------------------------------------------------------------------------
interface srrw_out_if;
    logic        valid;
    logic        ready;
    logic [1:0]  result_kind;
    logic [4:0]  out_seq;
    logic [31:0] out_handle;
    logic [9:0]  out_length;
    logic        last;

    modport source (
        output valid, result_kind, out_seq, out_handle, out_length, last,
        input  ready
    );

    modport sink (
        input  valid, result_kind, out_seq, out_handle, out_length, last,
        output ready
    );
endinterface

// ===== sv/selective_repeat_receive_window.sv =====
// ----------------------------------------------------------------------------
// selective_repeat_receive_window: selective-repeat ARQ receive window
// Classifies each packet against the expected sequence number, buffers
// packets ahead in the window, delivers in order and drains buffered entries.
// ----------------------------------------------------------------------------
//
//  Channel   Direction  Handshake        Payload
//  packet    in         valid/ready      packet_kind, seq_num, payload_handle,
//                                        payload_length
//  result    out        valid/ready      result_kind, out_seq, out_handle,
//                                        out_length, last
//  cfg       in         write enable     window_size (5 bits)
//
//  A packet that is acked only passes accept, classify and emit; an ignored
//  packet passes accept and classify. An in-order packet is delivered and
//  acked, then each drained entry passes probe, the registered slot RAM read and emit.
//  Packets are accepted only while the sequencer is idle.
//  A stalled result holds in the output register until the sink takes it.
//  Reset clears the valid bitmap at once; no clearing pass is needed.
// ----------------------------------------------------------------------------
module selective_repeat_receive_window #(
    parameter int SEQ_SPACE = 32
) (
    input  logic         clk,
    input  logic         rst_n,
    srrw_in_if.sink      packet,
    srrw_out_if.source   result,
    input  logic         cfg_write_en,
    input  logic [4:0]   cfg_write_data
);

    localparam int SEQ_W   = $clog2(SEQ_SPACE);
    localparam int CNT_W   = $clog2(SEQ_SPACE + 1);
    localparam int NW      = SEQ_W + 1;
    localparam int WIN_MAX = (srrw_pkg::WIN_CAP < SEQ_SPACE / 2) ?
                             srrw_pkg::WIN_CAP : SEQ_SPACE / 2;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_CLASS,
        ST_ACK,
        ST_PROBE,
        ST_READ,
        ST_EMIT
    } state_t;

    state_t                 state_reg;
    logic [4:0]             window_reg;
    logic [SEQ_W-1:0]       exp_reg;
    logic [SEQ_SPACE-1:0]   held_reg;
    logic [CNT_W-1:0]       held_count_reg;
    logic                   finished_reg;
    logic                   ack_pend_reg;
    logic [SEQ_W-1:0]       drain_seq_reg;
    logic                   drain_last_reg;

    // Captured packet.
    logic                   pkt_kind_reg;
    logic [4:0]             pkt_seq_reg;
    logic [31:0]            pkt_handle_reg;
    logic [9:0]             pkt_length_reg;

    // Output register.
    logic [1:0]             res_kind_reg;
    logic [4:0]             res_seq_reg;
    logic [31:0]            res_handle_reg;
    logic [9:0]             res_length_reg;
    logic                   res_last_reg;

    srrw_pkg::alu_op_t      alu_op;
    logic [SEQ_W-1:0]       alu_a;
    logic [SEQ_W-1:0]       alu_y;
    logic [SEQ_W-1:0]       seq_idx;
    logic                   seq_ok;
    logic [NW-1:0]          win_n;
    logic [NW-1:0]          seq_gap;
    logic                   in_order;
    logic                   ahead;
    logic                   dup;
    logic                   ram_wr_en;
    srrw_pkg::slot_entry_t  ram_wr_data;
    srrw_pkg::slot_entry_t  ram_rd_data;

    // Effective window: zero counts as one, large values saturate.
    always_comb
    begin
        if (window_reg == 5'd0)
        begin
            win_n = NW'(1);
        end
        else if (6'(window_reg) > 6'(WIN_MAX))
        begin
            win_n = NW'(WIN_MAX);
        end
        else
        begin
            win_n = NW'(window_reg);
        end
    end

    // The shared unit measures distance in classify and steps otherwise.
    assign seq_idx = SEQ_W'(pkt_seq_reg);
    assign seq_ok  = 9'(pkt_seq_reg) < 9'(SEQ_SPACE);
    assign alu_op  = (state_reg == ST_CLASS) ? srrw_pkg::OP_DIFF : srrw_pkg::OP_INC;
    assign alu_a   = (state_reg == ST_CLASS) ? seq_idx : exp_reg;

    srrw_seq_alu #(
        .SEQ_SPACE (SEQ_SPACE)
    ) u_alu (
        .op (alu_op),
        .a  (alu_a),
        .b  (exp_reg),
        .y  (alu_y)
    );

    // Window classification of the captured packet.
    assign seq_gap  = {1'b0, alu_y};
    assign in_order = (alu_y == '0);
    assign ahead    = seq_gap < win_n;
    assign dup      = seq_gap >= (NW'(SEQ_SPACE) - win_n);

    // A fresh packet ahead in the window goes into slot RAM.
    assign ram_wr_en   = (state_reg == ST_CLASS) && !finished_reg &&
                         (pkt_kind_reg == srrw_pkg::PK_DATA) && seq_ok &&
                         !in_order && ahead && !held_reg[seq_idx];
    assign ram_wr_data = '{handle: pkt_handle_reg, length: pkt_length_reg};

    srrw_ram #(
        .WIDTH ($bits(srrw_pkg::slot_entry_t)),
        .DEPTH (SEQ_SPACE)
    ) u_slot_ram (
        .clk     (clk),
        .wr_en   (ram_wr_en),
        .wr_addr (seq_idx),
        .wr_data (ram_wr_data),
        .rd_en   (state_reg == ST_PROBE),
        .rd_addr (exp_reg),
        .rd_data (ram_rd_data)
    );

    // Window register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            window_reg <= srrw_pkg::WIN_RESET;
        end
        else if (cfg_write_en)
        begin
            window_reg <= cfg_write_data;
        end
    end

    // Sequencer, window state and output register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            exp_reg        <= '0;
            held_reg       <= '0;
            held_count_reg <= '0;
            finished_reg   <= 1'b0;
            ack_pend_reg   <= 1'b0;
            drain_seq_reg  <= '0;
            drain_last_reg <= 1'b0;
            pkt_kind_reg   <= 1'b0;
            pkt_seq_reg    <= '0;
            pkt_handle_reg <= '0;
            pkt_length_reg <= '0;
            res_kind_reg   <= srrw_pkg::RK_DELIVER;
            res_seq_reg    <= '0;
            res_handle_reg <= '0;
            res_length_reg <= '0;
            res_last_reg   <= 1'b0;
        end
        else
        begin
            case (state_reg)
                ST_IDLE:
                begin
                    if (packet.valid)
                    begin
                        pkt_kind_reg   <= packet.packet_kind;
                        pkt_seq_reg    <= packet.seq_num;
                        pkt_handle_reg <= packet.payload_handle;
                        pkt_length_reg <= packet.payload_length;
                        state_reg      <= ST_CLASS;
                    end
                end
                ST_CLASS:
                begin
                    res_seq_reg <= pkt_seq_reg;
                    if (finished_reg)
                    begin
                        state_reg <= ST_IDLE;
                    end
                    else if (pkt_kind_reg == srrw_pkg::PK_EOT)
                    begin
                        // The EOT reply goes out only with an empty buffer.
                        if (held_count_reg == '0)
                        begin
                            res_kind_reg   <= srrw_pkg::RK_EOT;
                            res_handle_reg <= '0;
                            res_length_reg <= '0;
                            res_last_reg   <= 1'b1;
                            finished_reg   <= 1'b1;
                            state_reg      <= ST_EMIT;
                        end
                        else
                        begin
                            state_reg <= ST_IDLE;
                        end
                    end
                    else if (seq_ok && in_order)
                    begin
                        res_kind_reg   <= srrw_pkg::RK_DELIVER;
                        res_handle_reg <= pkt_handle_reg;
                        res_length_reg <= pkt_length_reg;
                        res_last_reg   <= 1'b0;
                        ack_pend_reg   <= 1'b1;
                        state_reg      <= ST_EMIT;
                    end
                    else if (seq_ok && (ahead || dup))
                    begin
                        // A fresh packet ahead is stored once; both cases are acked.
                        if (ahead && !held_reg[seq_idx])
                        begin
                            held_reg[seq_idx] <= 1'b1;
                            held_count_reg    <= held_count_reg + CNT_W'(1);
                        end
                        res_kind_reg   <= srrw_pkg::RK_ACK;
                        res_handle_reg <= '0;
                        res_length_reg <= '0;
                        res_last_reg   <= 1'b1;
                        state_reg      <= ST_EMIT;
                    end
                    else
                    begin
                        state_reg <= ST_IDLE;
                    end
                end
                ST_ACK:
                begin
                    // Ack the in-order packet and advance the window.
                    res_kind_reg   <= srrw_pkg::RK_ACK;
                    res_seq_reg    <= pkt_seq_reg;
                    res_handle_reg <= '0;
                    res_length_reg <= '0;
                    res_last_reg   <= !held_reg[alu_y];
                    exp_reg        <= alu_y;
                    ack_pend_reg   <= 1'b0;
                    state_reg      <= ST_EMIT;
                end
                ST_PROBE:
                begin
                    // Release the next buffered entry; its data arrives next.
                    drain_seq_reg     <= exp_reg;
                    drain_last_reg    <= !held_reg[alu_y];
                    held_reg[exp_reg] <= 1'b0;
                    held_count_reg    <= held_count_reg - CNT_W'(1);
                    exp_reg           <= alu_y;
                    state_reg         <= ST_READ;
                end
                ST_READ:
                begin
                    res_kind_reg   <= srrw_pkg::RK_DELIVER;
                    res_seq_reg    <= 5'(drain_seq_reg);
                    res_handle_reg <= ram_rd_data.handle;
                    res_length_reg <= ram_rd_data.length;
                    res_last_reg   <= drain_last_reg;
                    state_reg      <= ST_EMIT;
                end
                ST_EMIT:
                begin
                    if (result.ready)
                    begin
                        if (res_last_reg)
                        begin
                            state_reg <= ST_IDLE;
                        end
                        else if (ack_pend_reg)
                        begin
                            state_reg <= ST_ACK;
                        end
                        else
                        begin
                            state_reg <= ST_PROBE;
                        end
                    end
                end
                default:
                begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    // Channel outputs.
    assign packet.ready       = (state_reg == ST_IDLE);
    assign result.valid       = (state_reg == ST_EMIT);
    assign result.result_kind = res_kind_reg;
    assign result.out_seq     = res_seq_reg;
    assign result.out_handle  = res_handle_reg;
    assign result.out_length  = res_length_reg;
    assign result.last        = res_last_reg;

`ifndef SYNTH
    // The fill count tracks the bitmap exactly.
    assert property (@(posedge clk) disable iff (!rst_n)
        held_count_reg == CNT_W'($countones(held_reg)))
        else $error("held count does not match the slot bitmap");

    // Between packets the slot at the expected sequence number is never held.
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_IDLE) |-> !held_reg[exp_reg])
        else $error("expected slot is marked held while idle");

    // An EOT reply only leaves with an empty buffer and closes the item.
    assert property (@(posedge clk) disable iff (!rst_n)
        (result.valid && result.result_kind == srrw_pkg::RK_EOT) |->
        (held_count_reg == '0 && result.last && finished_reg))
        else $error("EOT reply with buffered entries");

    // After end of transmission a packet produces no result.
    assert property (@(posedge clk) disable iff (!rst_n)
        (finished_reg && packet.valid && packet.ready) |=> ##1
        (state_reg == ST_IDLE))
        else $error("result after end of transmission");

    // A delivered entry that was drained comes with a deliver code.
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_READ) |=>
        (result.valid && result.result_kind == srrw_pkg::RK_DELIVER))
        else $error("drain did not produce a delivery");
`endif

endmodule

// ===== sv/srrw_ram.sv =====
// ----------------------------------------------------------------------------
// srrw_ram: generic single-write, single-read RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module srrw_ram #(
    parameter int WIDTH = 42,
    parameter int DEPTH = 32
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    // Write port and registered read port.
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

// ===== sv/srrw_seq_alu.sv =====
// ----------------------------------------------------------------------------
// srrw_seq_alu: shared sequence-number unit
// Computes the modular distance of two sequence numbers or the modular
// successor of one, over a sequence space of SEQ_SPACE numbers.
// ----------------------------------------------------------------------------
module srrw_seq_alu #(
    parameter int SEQ_SPACE = 32
) (
    input  srrw_pkg::alu_op_t                op,
    input  logic [$clog2(SEQ_SPACE)-1:0]     a,
    input  logic [$clog2(SEQ_SPACE)-1:0]     b,
    output logic [$clog2(SEQ_SPACE)-1:0]     y
);

    localparam int SEQ_W = $clog2(SEQ_SPACE);

    logic [SEQ_W:0] diff;
    logic [SEQ_W:0] diff_wrap;

    // A borrow out of the subtraction means the distance wrapped.
    assign diff      = {1'b0, a} - {1'b0, b};
    assign diff_wrap = diff + (SEQ_W + 1)'(SEQ_SPACE);

    always_comb
    begin
        case (op)
            srrw_pkg::OP_DIFF:
            begin
                y = diff[SEQ_W] ? diff_wrap[SEQ_W-1:0] : diff[SEQ_W-1:0];
            end
            srrw_pkg::OP_INC:
            begin
                y = (a == SEQ_W'(SEQ_SPACE - 1)) ? '0 : a + SEQ_W'(1);
            end
            default:
            begin
                y = '0;
            end
        endcase
    end

endmodule
